FILE: rtl/multi_deque_manager_with_splice_macros.svh
// Assertion macros for the deque manager.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MULTI_DEQUE_MANAGER_WITH_SPLICE_MACROS_SVH
`define MULTI_DEQUE_MANAGER_WITH_SPLICE_MACROS_SVH

// same-cycle implication
`define MDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mdq_pkg.sv
// Shared constants, types and index helpers of the deque manager.
// No dependencies.
`default_nettype none

package mdq_pkg;

  localparam int unsigned NUM_QUEUES     = 16;
  localparam int unsigned QUEUE_CAPACITY = 64;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned QFIELD_W = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ELEM_W   = 32;

  localparam int unsigned DQW         = $clog2(NUM_QUEUES);
  localparam int unsigned HW          = $clog2(QUEUE_CAPACITY);
  localparam int unsigned CW          = $clog2(QUEUE_CAPACITY + 1);
  localparam int unsigned STORE_DEPTH = NUM_QUEUES * QUEUE_CAPACITY;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_MERGE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGT,
    S_POP,
    S_SRC,
    S_MOVE,
    S_MFIN
  } state_e;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [CW-1:0] count;
  } desc_t;

  typedef struct packed {
    logic           en;
    logic [DQW-1:0] addr;
    desc_t          data;
  } desc_wr_t;

  typedef struct packed {
    logic              en;
    logic [AW-1:0]     addr;
    logic [ELEM_W-1:0] data;
  } elem_wr_t;

  function automatic logic [HW-1:0] pos_add(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic [HW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (HW+1)'(QUEUE_CAPACITY)) begin
      s = s - (HW+1)'(QUEUE_CAPACITY);
    end
    return s[HW-1:0];
  endfunction

  function automatic logic [HW-1:0] pos_dec(input logic [HW-1:0] a);
    logic [HW-1:0] r;
    if (a == '0) begin
      r = HW'(QUEUE_CAPACITY - 1);
    end else begin
      r = a - HW'(1);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [DQW-1:0] q, input logic [HW-1:0] pos);
    logic [AW-1:0] base;
    base = AW'(q) * AW'(QUEUE_CAPACITY);
    return base + AW'(pos);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/multi_deque_manager_with_splice.sv
// Deque manager: a bank of double-ended queues of signed 32-bit values with
// push, pop and merge. Depends on mdq_pkg, mdq_elem_ram, mdq_desc_ram and
// multi_deque_manager_with_splice_macros.svh.
//
// Command channel: an item (mode, queues, end, order, value) is taken at a
// clock edge with start high and busy low. Each item yields one result,
// shown on status_o and popped_value_o for one cycle with result_valid_o
// high; the receiver cannot stall it.
// The result strobe is high in the cycle in which busy first drops. Cost is
// set by the registered reads of the descriptor and element stores: each item
// first reads its queue descriptor, a merge then reads the source descriptor
// and streams one element per cycle through the element store.
// Reset empties all queues at once through the descriptor valid bits; the
// element store keeps its contents and is never read before written.
`default_nettype none

module multi_deque_manager_with_splice (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [mdq_pkg::MODE_W-1:0]          mode_i,
  input  logic [mdq_pkg::QFIELD_W-1:0]        target_queue_i,
  input  logic [mdq_pkg::QFIELD_W-1:0]        source_queue_i,
  input  logic                                at_back_i,
  input  logic                                reversed_i,
  input  logic signed [mdq_pkg::ELEM_W-1:0]   push_value_i,
  output logic                                result_valid_o,
  output logic [mdq_pkg::STATUS_W-1:0]        status_o,
  output logic signed [mdq_pkg::ELEM_W-1:0]   popped_value_o
);
  import mdq_pkg::*;

  `include "multi_deque_manager_with_splice_macros.svh"

  state_e state_q, state_d;

  logic [MODE_W-1:0]   item_mode_q;
  logic [QFIELD_W-1:0] item_tgt_q;
  logic [QFIELD_W-1:0] item_src_q;
  logic                item_back_q;
  logic                item_rev_q;
  logic [ELEM_W-1:0]   item_val_q;

  desc_t         tdesc_q, tdesc_d;
  logic [HW-1:0] s_head_q, s_head_d;
  logic [CW-1:0] s_cnt_q, s_cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic          wr_pend_q, wr_pend_d;

  logic              res_vld_q, res_vld_d;
  status_e           status_q, status_d;
  logic [ELEM_W-1:0] popped_q, popped_d;

  logic              desc_rd_en;
  logic [DQW-1:0]    desc_rd_addr;
  desc_t             desc_rdata;
  desc_wr_t          desc_wr;
  logic              elem_rd_en;
  logic [AW-1:0]     elem_rd_addr;
  logic [ELEM_W-1:0] elem_rdata;
  elem_wr_t          elem_wr;

  logic           accept;
  logic           tgt_ok;
  logic           src_ok;
  logic           merge_go;
  logic [DQW-1:0] tgt_idx;
  logic [DQW-1:0] src_idx;
  logic           tgt_full;
  logic           tgt_empty;
  logic [CW-1:0]  room;
  logic           rd_more;
  logic           mv_done;
  logic [HW-1:0]  src_off;
  logic [HW-1:0]  tgt_off;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign tgt_idx   = DQW'(item_tgt_q);
  assign src_idx   = DQW'(item_src_q);
  assign tgt_ok    = (32'(item_tgt_q) < NUM_QUEUES);
  assign src_ok    = (32'(item_src_q) < NUM_QUEUES);
  assign merge_go  = tgt_ok && src_ok && (item_tgt_q != item_src_q);
  assign tgt_full  = (desc_rdata.count >= CW'(QUEUE_CAPACITY));
  assign tgt_empty = (desc_rdata.count == '0);
  assign room      = CW'(QUEUE_CAPACITY) - tdesc_q.count;
  assign rd_more   = (rd_idx_q != k_q);
  assign mv_done   = !rd_more && !wr_pend_q;
  assign src_off   = item_rev_q ? HW'(s_cnt_q - CW'(1) - rd_idx_q) : HW'(rd_idx_q);
  assign tgt_off   = HW'(tdesc_q.count + wr_idx_q);

  mdq_desc_ram u_desc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (desc_rd_en),
    .rd_addr_i (desc_rd_addr),
    .rd_data_o (desc_rdata),
    .wr_i      (desc_wr)
  );

  mdq_elem_ram u_elem (
    .clk_i     (clk_i),
    .rd_en_i   (elem_rd_en),
    .rd_addr_i (elem_rd_addr),
    .rd_data_o (elem_rdata),
    .wr_i      (elem_wr)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_TGT;
        end
      end
      S_TGT: begin
        case (mode_e'(item_mode_q))
          MODE_POP: begin
            state_d = (tgt_ok && !tgt_empty) ? S_POP : S_IDLE;
          end
          MODE_MERGE: begin
            state_d = merge_go ? S_SRC : S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_POP:  state_d = S_IDLE;
      S_SRC:  state_d = S_MOVE;
      S_MOVE: begin
        if (mv_done) begin
          state_d = S_MFIN;
        end
      end
      S_MFIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    desc_rd_en   = 1'b0;
    desc_rd_addr = tgt_idx;
    desc_wr      = '0;
    elem_rd_en   = 1'b0;
    elem_rd_addr = '0;
    elem_wr      = '0;
    res_vld_d    = 1'b0;
    status_d     = status_q;
    popped_d     = popped_q;
    tdesc_d      = tdesc_q;
    s_head_d     = s_head_q;
    s_cnt_d      = s_cnt_q;
    k_d          = k_q;
    ovf_d        = ovf_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    wr_pend_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        desc_rd_en   = accept;
        desc_rd_addr = DQW'(target_queue_i);
      end
      S_TGT: begin
        tdesc_d  = desc_rdata;
        status_d = STATUS_OK;
        popped_d = '0;
        case (mode_e'(item_mode_q))
          MODE_PUSH: begin
            res_vld_d = 1'b1;
            if (tgt_ok) begin
              if (tgt_full) begin
                status_d = STATUS_OVERFLOW;
              end else if (item_back_q) begin
                elem_wr.en        = 1'b1;
                elem_wr.addr      = slot_addr(tgt_idx,
                                      pos_add(desc_rdata.head, HW'(desc_rdata.count)));
                elem_wr.data      = item_val_q;
                desc_wr.en        = 1'b1;
                desc_wr.addr      = tgt_idx;
                desc_wr.data.head = desc_rdata.head;
                desc_wr.data.count = desc_rdata.count + CW'(1);
              end else begin
                elem_wr.en        = 1'b1;
                elem_wr.addr      = slot_addr(tgt_idx, pos_dec(desc_rdata.head));
                elem_wr.data      = item_val_q;
                desc_wr.en        = 1'b1;
                desc_wr.addr      = tgt_idx;
                desc_wr.data.head = pos_dec(desc_rdata.head);
                desc_wr.data.count = desc_rdata.count + CW'(1);
              end
            end
          end
          MODE_POP: begin
            if (!tgt_ok || tgt_empty) begin
              res_vld_d = 1'b1;
              status_d  = STATUS_EMPTY;
            end else begin
              elem_rd_en         = 1'b1;
              desc_wr.en         = 1'b1;
              desc_wr.addr       = tgt_idx;
              desc_wr.data.count = desc_rdata.count - CW'(1);
              if (item_back_q) begin
                elem_rd_addr      = slot_addr(tgt_idx, pos_add(desc_rdata.head,
                                      HW'(desc_rdata.count - CW'(1))));
                desc_wr.data.head = desc_rdata.head;
              end else begin
                elem_rd_addr      = slot_addr(tgt_idx, desc_rdata.head);
                desc_wr.data.head = pos_add(desc_rdata.head, HW'(1));
              end
            end
          end
          MODE_MERGE: begin
            if (merge_go) begin
              desc_rd_en   = 1'b1;
              desc_rd_addr = src_idx;
            end else begin
              res_vld_d = 1'b1;
            end
          end
          default: begin
            res_vld_d = 1'b1;
          end
        endcase
      end
      S_POP: begin
        res_vld_d = 1'b1;
        status_d  = STATUS_OK;
        popped_d  = elem_rdata;
      end
      S_SRC: begin
        s_head_d  = desc_rdata.head;
        s_cnt_d   = desc_rdata.count;
        k_d       = (desc_rdata.count < room) ? desc_rdata.count : room;
        ovf_d     = (desc_rdata.count > room);
        rd_idx_d  = '0;
        wr_idx_d  = '0;
        desc_wr.en         = 1'b1;
        desc_wr.addr       = src_idx;
        desc_wr.data.count = '0;
        desc_wr.data.head  = item_rev_q ? desc_rdata.head
                                        : pos_add(desc_rdata.head, HW'(desc_rdata.count));
      end
      S_MOVE: begin
        if (rd_more) begin
          elem_rd_en   = 1'b1;
          elem_rd_addr = slot_addr(src_idx, pos_add(s_head_q, src_off));
          rd_idx_d     = rd_idx_q + CW'(1);
          wr_pend_d    = 1'b1;
        end
        if (wr_pend_q) begin
          elem_wr.en   = 1'b1;
          elem_wr.addr = slot_addr(tgt_idx, pos_add(tdesc_q.head, tgt_off));
          elem_wr.data = elem_rdata;
          wr_idx_d     = wr_idx_q + CW'(1);
        end
      end
      S_MFIN: begin
        desc_wr.en         = 1'b1;
        desc_wr.addr       = tgt_idx;
        desc_wr.data.head  = tdesc_q.head;
        desc_wr.data.count = tdesc_q.count + k_q;
        res_vld_d          = 1'b1;
        status_d           = ovf_q ? STATUS_OVERFLOW : STATUS_OK;
        popped_d           = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_vld_q <= 1'b0;
      wr_pend_q <= 1'b0;
      rd_idx_q  <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      wr_pend_q <= wr_pend_d;
      rd_idx_q  <= rd_idx_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_mode_q <= mode_i;
      item_tgt_q  <= target_queue_i;
      item_src_q  <= source_queue_i;
      item_back_q <= at_back_i;
      item_rev_q  <= reversed_i;
      item_val_q  <= push_value_i;
    end
    tdesc_q  <= tdesc_d;
    s_head_q <= s_head_d;
    s_cnt_q  <= s_cnt_d;
    ovf_q    <= ovf_d;
    wr_idx_q <= wr_idx_d;
    status_q <= status_d;
    popped_q <= popped_d;
  end

  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;

  `MDQ_ASSERT_NXT(a_accept_busy, accept, busy, "busy not raised after an accepted item")
  `MDQ_ASSERT_IMP(a_result_after_busy, result_valid_o, $past(busy), "result without a busy item")
  `MDQ_ASSERT_IMP(a_desc_no_overlap, desc_wr.en && desc_rd_en, desc_wr.addr != desc_rd_addr, "descriptor read and write collide")
  `MDQ_ASSERT_IMP(a_count_bound, desc_wr.en, desc_wr.data.count <= CW'(QUEUE_CAPACITY), "queue count above capacity")

endmodule

`default_nettype wire

FILE: rtl/mdq_elem_ram.sv
// Element store: one write port, one read port, registered read data.
// Depends on mdq_pkg.
`default_nettype none

module mdq_elem_ram (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [mdq_pkg::AW-1:0]         rd_addr_i,
  output logic [mdq_pkg::ELEM_W-1:0]     rd_data_o,
  input  mdq_pkg::elem_wr_t              wr_i
);
  import mdq_pkg::*;

  logic [ELEM_W-1:0] mem_q [STORE_DEPTH];
  logic [ELEM_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

FILE: rtl/mdq_desc_ram.sv
// Queue descriptor store (head and count per queue) with per-entry valid bits.
// An entry never written reads as an empty queue at slot zero. Depends on mdq_pkg.
`default_nettype none

module mdq_desc_ram (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rd_en_i,
  input  logic [mdq_pkg::DQW-1:0] rd_addr_i,
  output mdq_pkg::desc_t          rd_data_o,
  input  mdq_pkg::desc_wr_t       wr_i
);
  import mdq_pkg::*;

  desc_t                 mem_q [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld_q;
  desc_t                 rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for multi_deque_manager_with_splice: directed and random
// push, pop, merge and unused-mode items, each result checked against an in-bench
// deque model. Depends on mdq_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb;
  import mdq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 900;
  localparam int IDLE_END    = ITEM_TARGET - 150;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic [1:0] {CMD_OP, CMD_IDLE, CMD_DRAIN} cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [MODE_W-1:0]   mode;
    logic [QFIELD_W-1:0] tgt;
    logic [QFIELD_W-1:0] src;
    logic                back;
    logic                rev;
    logic [ELEM_W-1:0]   value;
    logic [3:0]          len;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   popped;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] mode_i = '0;
  logic [QFIELD_W-1:0] target_queue_i = '0;
  logic [QFIELD_W-1:0] source_queue_i = '0;
  logic at_back_i = 1'b0;
  logic reversed_i = 1'b0;
  logic signed [ELEM_W-1:0] push_value_i = '0;
  logic result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic signed [ELEM_W-1:0] popped_value_o;

  cmd_t        cmd_queue [$];
  result_t     due_results [$];
  cmd_t        cur_cmd;
  logic [3:0]  idle_left = '0;
  int          op_total = 0;
  int          accepted_cnt = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          n_push = 0, n_pop = 0, n_merge = 0, n_moved = 0, n_overflow = 0, n_empty = 0;
  bit          idle_on;

  logic [ELEM_W-1:0] deque_mem [NUM_QUEUES][QUEUE_CAPACITY];
  int unsigned       deque_head [NUM_QUEUES];
  int unsigned       deque_len [NUM_QUEUES];

  multi_deque_manager_with_splice dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .target_queue_i (target_queue_i),
    .source_queue_i (source_queue_i),
    .at_back_i      (at_back_i),
    .reversed_i     (reversed_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [ELEM_W-1:0] take_front(input int unsigned q);
    logic [ELEM_W-1:0] v;
    v = deque_mem[q][deque_head[q]];
    deque_head[q] = (deque_head[q] + 1) % QUEUE_CAPACITY;
    deque_len[q] = deque_len[q] - 1;
    return v;
  endfunction

  function automatic logic [ELEM_W-1:0] take_back(input int unsigned q);
    logic [ELEM_W-1:0] v;
    v = deque_mem[q][(deque_head[q] + deque_len[q] - 1) % QUEUE_CAPACITY];
    deque_len[q] = deque_len[q] - 1;
    return v;
  endfunction

  function automatic void put_back(input int unsigned q, input logic [ELEM_W-1:0] v);
    deque_mem[q][(deque_head[q] + deque_len[q]) % QUEUE_CAPACITY] = v;
    deque_len[q] = deque_len[q] + 1;
  endfunction

  function automatic void deque_apply(input cmd_t c);
    result_t           r;
    logic [ELEM_W-1:0] v;
    r.status = STATUS_OK;
    r.popped = '0;
    case (c.mode)
      MODE_PUSH: begin
        n_push++;
        if (deque_len[c.tgt] >= QUEUE_CAPACITY) begin
          r.status = STATUS_OVERFLOW;
        end else if (c.back) begin
          put_back(c.tgt, c.value);
        end else begin
          deque_head[c.tgt] = (deque_head[c.tgt] + QUEUE_CAPACITY - 1) % QUEUE_CAPACITY;
          deque_mem[c.tgt][deque_head[c.tgt]] = c.value;
          deque_len[c.tgt] = deque_len[c.tgt] + 1;
        end
      end
      MODE_POP: begin
        n_pop++;
        if (deque_len[c.tgt] == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.popped = c.back ? take_back(c.tgt) : take_front(c.tgt);
        end
      end
      MODE_MERGE: begin
        n_merge++;
        if (c.tgt != c.src) begin
          while (deque_len[c.src] != 0) begin
            v = c.rev ? take_back(c.src) : take_front(c.src);
            if (deque_len[c.tgt] >= QUEUE_CAPACITY) begin
              r.status = STATUS_OVERFLOW;
            end else begin
              put_back(c.tgt, v);
              n_moved++;
            end
          end
        end
      end
      default: ;
    endcase
    if (r.status == STATUS_OVERFLOW) n_overflow++;
    if (r.status == STATUS_EMPTY) n_empty++;
    accepted_cnt++;
    due_results.insert(due_results.size(), r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    cmd_t nxt;
    logic present;
    if (!rst_ni) begin
      start <= 1'b0;
      idle_left <= '0;
    end else if (!start || !busy) begin
      present = 1'b0;
      if (start) deque_apply(cur_cmd);
      if (idle_left != 0) begin
        idle_left <= idle_left - 1'b1;
      end else if (cmd_queue.size() != 0) begin
        nxt = cmd_queue[0];
        case (nxt.kind)
          CMD_IDLE: begin
            idle_left <= nxt.len - 1'b1;
            cmd_queue.delete(0);
          end
          CMD_DRAIN: begin
            if (due_results.size() == 0) cmd_queue.delete(0);
          end
          default: begin
            cmd_queue.delete(0);
            cur_cmd <= nxt;
            mode_i <= nxt.mode;
            target_queue_i <= nxt.tgt;
            source_queue_i <= nxt.src;
            at_back_i <= nxt.back;
            reversed_i <= nxt.rev;
            push_value_i <= nxt.value;
            present = 1'b1;
          end
        endcase
      end
      start <= present;
    end
  end

  always @(posedge clk_i) begin : watch_proc
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d popped_value %0d", status_o, popped_value_o);
        fail_cnt++;
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
          fail_cnt++;
        end
        if (popped_value_o !== want.popped) begin
          $error("popped_value mismatch: expected %0d, actual %0d",
                 $signed(want.popped), popped_value_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_idle(input int n);
    cmd_t c;
    c = '0;
    c.kind = CMD_IDLE;
    c.len = 4'(n);
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  task automatic add_drain();
    cmd_t c;
    c = '0;
    c.kind = CMD_DRAIN;
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  task automatic add_op(input logic [MODE_W-1:0] mode, input logic [QFIELD_W-1:0] tgt,
                        input logic [QFIELD_W-1:0] src, input logic back, input logic rev,
                        input logic [ELEM_W-1:0] value);
    cmd_t c;
    if (idle_on && op_total < IDLE_END && $urandom_range(0, 5) == 0) begin
      add_idle($urandom_range(1, 14));
    end
    c.kind = CMD_OP;
    c.mode = mode;
    c.tgt = tgt;
    c.src = src;
    c.back = back;
    c.rev = rev;
    c.value = value;
    c.len = '0;
    cmd_queue.insert(cmd_queue.size(), c);
    op_total++;
  endtask

  function automatic logic [ELEM_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stim_proc
    logic [QFIELD_W-1:0] pool [3];
    logic [QFIELD_W-1:0] qa, qb;
    int r, n;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      deque_head[q] = 0;
      deque_len[q] = 0;
    end
    idle_on = 1'b0;

    add_op(MODE_PUSH, 4'd0, 4'd9, 1'b1, 1'b0, 32'h7FFF_FFFF);
    add_op(MODE_PUSH, 4'd0, 4'd3, 1'b1, 1'b1, 32'h8000_0000);
    add_op(MODE_PUSH, 4'd0, 4'd0, 1'b0, 1'b0, 32'h0000_0000);
    add_op(MODE_PUSH, 4'd0, 4'd15, 1'b0, 1'b1, 32'hFFFF_FFFF);
    add_op(MODE_POP, 4'd0, 4'd0, 1'b0, 1'b0, 32'h0);
    add_op(MODE_POP, 4'd0, 4'd0, 1'b1, 1'b0, 32'h0);
    add_op(MODE_POP, 4'd5, 4'd0, 1'b0, 1'b0, 32'h0);
    add_op(MODE_UNUSED, 4'd0, 4'd1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_op(MODE_MERGE, 4'd0, 4'd0, 1'b0, 1'b0, 32'h0);
    add_op(MODE_MERGE, 4'd1, 4'd6, 1'b0, 1'b1, 32'h0);
    add_op(MODE_PUSH, 4'd1, 4'd0, 1'b1, 1'b0, 32'h0000_0005);
    add_op(MODE_MERGE, 4'd1, 4'd0, 1'b0, 1'b1, 32'h0);
    add_op(MODE_MERGE, 4'd15, 4'd1, 1'b1, 1'b0, 32'h0);
    add_op(MODE_POP, 4'd15, 4'd0, 1'b1, 1'b0, 32'h0);
    add_op(MODE_POP, 4'd15, 4'd0, 1'b0, 1'b0, 32'h0);
    add_op(MODE_POP, 4'd15, 4'd0, 1'b0, 1'b0, 32'h0);
    add_op(MODE_POP, 4'd15, 4'd0, 1'b1, 1'b0, 32'h0);
    add_drain();

    while (op_total < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 3; i++) pool[i] = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        2: begin
          qa = pool[0];
          qb = (pool[1] == qa) ? qa + 4'd1 : pool[1];
          n = $urandom_range(60, 70);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
              add_op(2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), 1'($urandom),
                     1'($urandom), rand_value());
            end
            add_op(MODE_PUSH, qa, 4'($urandom), 1'($urandom), 1'($urandom), rand_value());
          end
          n = $urandom_range(5, 30);
          for (int i = 0; i < n; i++) begin
            add_op(MODE_PUSH, qb, 4'($urandom), 1'($urandom), 1'($urandom), rand_value());
          end
          add_op(MODE_MERGE, qa, qb, 1'($urandom), 1'($urandom), rand_value());
          add_op(MODE_MERGE, qb, qa, 1'($urandom), 1'($urandom), rand_value());
          n = $urandom_range(5, 20);
          for (int i = 0; i < n; i++) begin
            add_op(MODE_POP, qb, 4'($urandom), 1'($urandom), 1'($urandom), rand_value());
          end
        end
        3: begin
          n = $urandom_range(10, 40);
          for (int i = 0; i < n; i++) begin
            add_op(MODE_POP, pool[$urandom_range(0, 2)], 4'($urandom), 1'($urandom),
                   1'($urandom), rand_value());
          end
        end
        default: begin
          for (int i = 0; i < 30; i++) begin
            r = $urandom_range(0, 19);
            qa = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 2)] : 4'($urandom);
            qb = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 2)] : 4'($urandom);
            if (r < 9) begin
              add_op(MODE_PUSH, qa, qb, 1'($urandom), 1'($urandom), rand_value());
            end else if (r < 16) begin
              add_op(MODE_POP, qa, qb, 1'($urandom), 1'($urandom), rand_value());
            end else if (r < 19) begin
              add_op(MODE_MERGE, qa, qb, 1'($urandom), 1'($urandom), rand_value());
            end else begin
              add_op(MODE_UNUSED, qa, qb, 1'($urandom), 1'($urandom), rand_value());
            end
          end
        end
      endcase
      if (op_total < IDLE_END && $urandom_range(0, 3) == 0) add_drain();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == op_total);
    wait (due_results.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d items: %0d push, %0d pop, %0d merge (%0d elements moved).",
             accepted_cnt, n_push, n_pop, n_merge, n_moved);
    $display("Saw %0d overflow and %0d empty-queue results.", n_overflow, n_empty);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mdq_pkg.sv
rtl/mdq_elem_ram.sv
rtl/mdq_desc_ram.sv
rtl/multi_deque_manager_with_splice.sv
tb/tb.sv
